>>> src/saec_pkg.sv
// saec_pkg: shared types and constants for the sensor average, smoothing and
// calibration block. Used by saec_ctrl, saec_dpath and the top level.
// No dependencies.
package saec_pkg;

	// Defaults for the top-level parameters
	localparam int WINDOW_MAX_DEFAULT  = 16;
	localparam int SAMPLE_BITS_DEFAULT = 12;

	// Fixed field widths of the configuration registers and results
	localparam int LEN_CFG_W  = 5;
	localparam int ALPHA_W    = 16;
	localparam int CAL_W      = 32;
	localparam int CFG_IDX_W  = 2;

	// Smoothing weight in Q1.15
	localparam int               ALPHA_FRAC = 15;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 16'h8000;

	// Shared multiplier: signed 33 x 17 covers the Q16.16 factor and any
	// unsigned 16-bit operand
	localparam int MUL_A_W = CAL_W + 1;
	localparam int MUL_B_W = 17;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Saturation limits of the calibrated result
	localparam logic [CAL_W-1:0] CAL_MAX = 32'h7fff_ffff;
	localparam logic [CAL_W-1:0] CAL_MIN = 32'h8000_0000;

	// Register reset values
	localparam logic [LEN_CFG_W-1:0] WINDOW_LENGTH_RESET = 5'd1;
	localparam logic [CAL_W-1:0]     CAL_FACTOR_RESET    = 32'h0001_0000;
	localparam logic [CAL_W-1:0]     CAL_OFFSET_RESET    = 32'h0000_0000;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_LENGTH = 2'd0,
		CFG_SMOOTH_ALPHA  = 2'd1,
		CFG_CAL_FACTOR    = 2'd2,
		CFG_CAL_OFFSET    = 2'd3
	} cfg_idx_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIVIDE,
		ST_MUL_NEW,
		ST_MUL_OLD,
		ST_MIX,
		ST_MUL_CAL,
		ST_CALIB
	} ctrl_state_t;

	// Operand pair for the shared multiplier
	typedef enum logic [1:0] {
		MUL_ALPHA_MEAN,
		MUL_BETA_PREV,
		MUL_FACTOR_SM
	} mul_sel_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic     accept;
		logic     update;
		logic     div_step;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_load;
		logic     mix_load;
		logic     result_load;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic div_last;
	} status_t;

endpackage

>>> src/saec_ctrl.sv
// saec_ctrl: sequencer for one sample request at a time and the result
// valid register. Depends on saec_pkg.
module saec_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	output logic                 result_valid,
	input  logic                 result_stall,
	input  saec_pkg::status_t    status,
	output saec_pkg::cmd_t       cmd
);

	saec_pkg::ctrl_state_t state_q, state_d;
	logic res_valid_q;
	logic out_free;

	// Output register may be loaded when empty or being taken this cycle
	assign out_free     = !res_valid_q || !result_stall;
	assign sample_stall = (state_q != saec_pkg::ST_IDLE);
	assign result_valid = res_valid_q;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= saec_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance through the sequence and issue commands
	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.mul_sel     = saec_pkg::MUL_ALPHA_MEAN;
		case (state_q)
			saec_pkg::ST_IDLE: begin
				if (sample_valid) begin
					cmd.accept = 1'b1;
					state_d    = saec_pkg::ST_UPDATE;
				end
			end
			saec_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = saec_pkg::ST_DIVIDE;
			end
			saec_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = saec_pkg::ST_MUL_NEW;
				end
			end
			saec_pkg::ST_MUL_NEW: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = saec_pkg::MUL_ALPHA_MEAN;
				state_d     = saec_pkg::ST_MUL_OLD;
			end
			saec_pkg::ST_MUL_OLD: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = saec_pkg::MUL_BETA_PREV;
				cmd.acc_load = 1'b1;
				state_d      = saec_pkg::ST_MIX;
			end
			saec_pkg::ST_MIX: begin
				cmd.mix_load = 1'b1;
				state_d      = saec_pkg::ST_MUL_CAL;
			end
			saec_pkg::ST_MUL_CAL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = saec_pkg::MUL_FACTOR_SM;
				state_d     = saec_pkg::ST_CALIB;
			end
			saec_pkg::ST_CALIB: begin
				if (out_free) begin
					cmd.result_load = 1'b1;
					state_d         = saec_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = saec_pkg::ST_IDLE;
			end
		endcase
	end

	// Result valid: set on load, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

endmodule

>>> src/saec_dpath.sv
// saec_dpath: configuration registers, sample window memory, running sum,
// serial divider, shared multiplier and output payload registers.
// Depends on saec_pkg.
module saec_dpath #(
	parameter int WINDOW_MAX  = saec_pkg::WINDOW_MAX_DEFAULT,
	parameter int SAMPLE_BITS = saec_pkg::SAMPLE_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [saec_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [saec_pkg::CAL_W-1:0]        cfg_data,
	input  logic [SAMPLE_BITS-1:0]            sample,
	input  saec_pkg::cmd_t                    cmd,
	output saec_pkg::status_t                 status,
	output logic [SAMPLE_BITS-1:0]            smoothed,
	output logic signed [saec_pkg::CAL_W-1:0] calibrated
);

	localparam int SLOT_W = $clog2(WINDOW_MAX);
	localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_MAX);
	localparam int CNT_W  = $clog2(SUM_W + 1);
	localparam int PAD_B  = saec_pkg::MUL_B_W - SAMPLE_BITS;
	localparam int PAD_C  = saec_pkg::PROD_W + 1 - saec_pkg::CAL_W;

	// Configuration registers
	logic [saec_pkg::LEN_CFG_W-1:0] wlen_q;
	logic [saec_pkg::ALPHA_W-1:0]   alpha_q;
	logic [saec_pkg::CAL_W-1:0]     factor_q;
	logic [saec_pkg::CAL_W-1:0]     offset_q;

	// Window state
	logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
	logic [WINDOW_MAX-1:0]  filled_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SLOT_W-1:0]      wslot_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [SAMPLE_BITS-1:0] rd_q;
	logic                   rd_filled_q;
	logic [SAMPLE_BITS-1:0] prev_q;

	// Divider
	logic [LEN_W-1:0]       rem_q;
	logic [SUM_W-1:0]       quo_q;
	logic [CNT_W-1:0]       cnt_q;

	// Multiplier and accumulator
	logic signed [saec_pkg::PROD_W-1:0] prod_q;
	logic signed [saec_pkg::PROD_W-1:0] acc_q;

	logic [LEN_W-1:0]            len;
	logic [SLOT_W-1:0]           rd_slot;
	logic [SLOT_W:0]             next_slot;
	logic [SAMPLE_BITS-1:0]      old_val;
	logic [SUM_W-1:0]            new_sum;
	logic [LEN_W:0]              trial;
	logic                        trial_ge;
	logic [SAMPLE_BITS-1:0]      mean;
	logic [saec_pkg::ALPHA_W-1:0] alpha_sat;
	logic [saec_pkg::ALPHA_W-1:0] beta;
	logic signed [saec_pkg::MUL_A_W-1:0] mul_a;
	logic signed [saec_pkg::MUL_B_W-1:0] mul_b;
	logic [saec_pkg::PROD_W-1:0] mix_sum;
	logic signed [saec_pkg::PROD_W:0] cal_sum;
	logic [saec_pkg::CAL_W-1:0]  cal_sat;

	// Effective window length: zero counts as one, clamp to the store depth
	always_comb begin
		if (wlen_q == '0) begin
			len = LEN_W'(1);
		end else if (32'(wlen_q) > WINDOW_MAX) begin
			len = LEN_W'(WINDOW_MAX);
		end else begin
			len = LEN_W'(wlen_q);
		end
	end

	// Slot to overwrite, wrapped when the window has been shortened
	assign rd_slot   = ({1'b0, wslot_q} >= (SLOT_W + 1)'(len)) ? '0 : wslot_q;
	assign next_slot = {1'b0, slot_q} + (SLOT_W + 1)'(1);
	assign old_val   = rd_filled_q ? rd_q : '0;
	assign new_sum   = sum_q - SUM_W'(old_val) + SUM_W'(sample_q);

	// One restoring division step
	assign trial    = {rem_q, quo_q[SUM_W-1]};
	assign trial_ge = (trial >= {1'b0, len});
	assign status.div_last = (cnt_q == CNT_W'(1));
	assign mean     = quo_q[SAMPLE_BITS-1:0];

	// Smoothing weights
	assign alpha_sat = (alpha_q > saec_pkg::ALPHA_ONE) ? saec_pkg::ALPHA_ONE : alpha_q;
	assign beta      = saec_pkg::ALPHA_ONE - alpha_sat;

	// Select multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			saec_pkg::MUL_ALPHA_MEAN: begin
				mul_a = $signed({17'b0, alpha_sat});
				mul_b = $signed({{PAD_B{1'b0}}, mean});
			end
			saec_pkg::MUL_BETA_PREV: begin
				mul_a = $signed({17'b0, beta});
				mul_b = $signed({{PAD_B{1'b0}}, prev_q});
			end
			saec_pkg::MUL_FACTOR_SM: begin
				mul_a = $signed({factor_q[saec_pkg::CAL_W-1], factor_q});
				mul_b = $signed({{PAD_B{1'b0}}, prev_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Blend and calibrate
	assign mix_sum = acc_q + prod_q;
	assign cal_sum = {prod_q[saec_pkg::PROD_W-1], prod_q}
		+ $signed({{PAD_C{offset_q[saec_pkg::CAL_W-1]}}, offset_q});

	// Saturate to 32 bits when the upper bits are not a pure sign extension
	always_comb begin
		if ((&cal_sum[saec_pkg::PROD_W:saec_pkg::CAL_W-1])
				|| !(|cal_sum[saec_pkg::PROD_W:saec_pkg::CAL_W-1])) begin
			cal_sat = cal_sum[saec_pkg::CAL_W-1:0];
		end else if (cal_sum[saec_pkg::PROD_W]) begin
			cal_sat = saec_pkg::CAL_MIN;
		end else begin
			cal_sat = saec_pkg::CAL_MAX;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q   <= saec_pkg::WINDOW_LENGTH_RESET;
			alpha_q  <= saec_pkg::ALPHA_ONE;
			factor_q <= saec_pkg::CAL_FACTOR_RESET;
			offset_q <= saec_pkg::CAL_OFFSET_RESET;
		end else if (cfg_write) begin
			case (saec_pkg::cfg_idx_t'(cfg_index))
				saec_pkg::CFG_WINDOW_LENGTH: wlen_q   <= cfg_data[saec_pkg::LEN_CFG_W-1:0];
				saec_pkg::CFG_SMOOTH_ALPHA:  alpha_q  <= cfg_data[saec_pkg::ALPHA_W-1:0];
				saec_pkg::CFG_CAL_FACTOR:    factor_q <= cfg_data;
				saec_pkg::CFG_CAL_OFFSET:    offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Window bookkeeping: a window length write drops all entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			sum_q    <= '0;
			wslot_q  <= '0;
		end else if (cfg_write
				&& (saec_pkg::cfg_idx_t'(cfg_index) == saec_pkg::CFG_WINDOW_LENGTH)) begin
			filled_q <= '0;
			sum_q    <= '0;
			wslot_q  <= '0;
		end else if (cmd.update) begin
			filled_q[slot_q] <= 1'b1;
			sum_q            <= new_sum;
			if (next_slot >= (SLOT_W + 1)'(len)) begin
				wslot_q <= '0;
			end else begin
				wslot_q <= next_slot[SLOT_W-1:0];
			end
		end
	end

	// Window memory: registered read on accept, write on update
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_q <= mem[rd_slot];
		end
		if (cmd.update) begin
			mem[slot_q] <= sample_q;
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q    <= sample;
			slot_q      <= rd_slot;
			rd_filled_q <= filled_q[rd_slot];
		end
	end

	// Serial divider: load on update, one quotient bit per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.update) begin
			cnt_q <= CNT_W'(SUM_W);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			rem_q <= '0;
			quo_q <= new_sum;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? LEN_W'(trial - {1'b0, len}) : trial[LEN_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], trial_ge};
		end
	end

	// Shared multiplier and partial-sum register
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.acc_load) begin
			acc_q <= prod_q;
		end
	end

	// Smoothed value becomes the stored previous value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (cmd.mix_load) begin
			prev_q <= mix_sum[saec_pkg::ALPHA_FRAC +: SAMPLE_BITS];
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			smoothed   <= prev_q;
			calibrated <= cal_sat;
		end
	end

endmodule

>>> src/sensor_average_exp_calibrate.sv
// Sensor moving average, exponential smoothing and linear calibration.
// Per accepted request: window update, serial divide (the longest step), two
// smoothing multiplies, mix, calibration multiply, then the result load, which
// waits while a held result is stalled; no new request is taken before it.
// Reset (arst_n low): window empty, sum, slot and previous value zero, registers
// at their reset values; no clearing pass is needed.
module sensor_average_exp_calibrate #(
	parameter int WINDOW_MAX  = saec_pkg::WINDOW_MAX_DEFAULT,
	parameter int SAMPLE_BITS = saec_pkg::SAMPLE_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [saec_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [saec_pkg::CAL_W-1:0]        cfg_data,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  logic [SAMPLE_BITS-1:0]            sample,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [SAMPLE_BITS-1:0]            smoothed,
	output logic signed [saec_pkg::CAL_W-1:0] calibrated
);

	saec_pkg::cmd_t    cmd;
	saec_pkg::status_t status;
	logic              cfg_write;

	// Registers are always writable
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	saec_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	saec_dpath #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample     (sample),
		.cmd        (cmd),
		.status     (status),
		.smoothed   (smoothed),
		.calibrated (calibrated)
	);

	// Busy from the cycle after a request is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> sample_stall)
		else $error("sample request taken but block not busy next cycle");

	// A new result never overwrites one still held by the consumer
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result_load |-> !(result_valid && result_stall))
		else $error("result register overwritten while stalled");

	// Sequencer issues at most one phase command per cycle
	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.update, cmd.div_step, cmd.mul_en,
			cmd.mix_load, cmd.result_load}))
		else $error("overlapping datapath commands");

	// A fresh result leaves the block ready for the next request
	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !sample_stall)
		else $error("block still busy after delivering a result");

endmodule

>>> tb/sv/sensor_average_exp_calibrate_check.sv
`timescale 1ns / 1ps
// Checker for sensor_average_exp_calibrate: watches the register, sample and result
// channels, predicts every reading from its own filter state and compares it.
// Depends on saec_pkg for widths, register indexes and the Q1.15 unit.
module sensor_average_exp_calibrate_check #(
	parameter int WINDOW_MAX  = saec_pkg::WINDOW_MAX_DEFAULT,
	parameter int SAMPLE_BITS = saec_pkg::SAMPLE_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [saec_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [saec_pkg::CAL_W-1:0]        cfg_data,
	input  logic                              sample_valid,
	input  logic                              sample_stall,
	input  logic [SAMPLE_BITS-1:0]            sample,
	input  logic                              result_valid,
	input  logic                              result_stall,
	input  logic [SAMPLE_BITS-1:0]            smoothed,
	input  logic signed [saec_pkg::CAL_W-1:0] calibrated,
	output int                                pending,
	output int                                compared,
	output int                                saturated,
	output int                                failures
);

	localparam longint CAL_HI      = 64'sd2147483647;
	localparam longint CAL_LO      = -64'sd2147483648;
	localparam int     PRINT_LIMIT = 30;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0]       smoothed;
		logic [saec_pkg::CAL_W-1:0]   calibrated;
	} reading_t;

	// Filter state
	logic [SAMPLE_BITS-1:0] win_taps [WINDOW_MAX];
	int unsigned            win_total;
	int unsigned            next_tap;
	logic [SAMPLE_BITS-1:0] last_smoothed;

	// Register copies
	logic [saec_pkg::LEN_CFG_W-1:0]  avg_len;
	logic [saec_pkg::ALPHA_W-1:0]    alpha_q15;
	logic signed [saec_pkg::CAL_W-1:0] cal_gain;
	logic signed [saec_pkg::CAL_W-1:0] cal_bias;

	reading_t awaited_readings [$];
	reading_t oldest;

	task automatic report_mismatch(input string msg);
		failures++;
		if (failures <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic clear_window();
		for (int i = 0; i < WINDOW_MAX; i++)
			win_taps[i] = '0;
		win_total = 0;
		next_tap  = 0;
	endtask

	task automatic apply_register(input saec_pkg::cfg_idx_t idx,
			input logic [saec_pkg::CAL_W-1:0] d);
		case (idx)
			saec_pkg::CFG_WINDOW_LENGTH: begin
				avg_len = d[saec_pkg::LEN_CFG_W-1:0];
				clear_window();
			end
			saec_pkg::CFG_SMOOTH_ALPHA: alpha_q15 = d[saec_pkg::ALPHA_W-1:0];
			saec_pkg::CFG_CAL_FACTOR:   cal_gain  = d;
			saec_pkg::CFG_CAL_OFFSET:   cal_bias  = d;
			default: ;
		endcase
	endtask

	// Push one sample through window, smoothing and calibration
	task automatic predict_reading(input logic [SAMPLE_BITS-1:0] s);
		int unsigned       len;
		int unsigned       slot;
		longint unsigned   mean;
		longint unsigned   alpha;
		longint unsigned   mix;
		longint unsigned   shifted;
		longint            cal;
		reading_t          r;
		len = (avg_len == '0) ? 1 : (32'(avg_len) > WINDOW_MAX) ? WINDOW_MAX : 32'(avg_len);
		slot = (next_tap >= len) ? 0 : next_tap;
		win_total = win_total - 32'(win_taps[slot]) + 32'(s);
		win_taps[slot] = s;
		slot++;
		next_tap = (slot >= len) ? 0 : slot;
		mean = 64'(win_total / len);

		// Weigh the new mean against the stored reading
		alpha = (alpha_q15 > saec_pkg::ALPHA_ONE) ? 64'(saec_pkg::ALPHA_ONE)
			: 64'(alpha_q15);
		mix = mean * alpha + 64'(last_smoothed) * (64'(saec_pkg::ALPHA_ONE) - alpha);
		shifted = mix >> saec_pkg::ALPHA_FRAC;
		r.smoothed = shifted[SAMPLE_BITS-1:0];
		last_smoothed = r.smoothed;

		// Scale and offset, then clamp to 32 bits
		cal = longint'(cal_gain) * longint'({1'b0, r.smoothed}) + longint'(cal_bias);
		if (cal > CAL_HI) begin
			cal = CAL_HI;
			saturated++;
		end else if (cal < CAL_LO) begin
			cal = CAL_LO;
			saturated++;
		end
		r.calibrated = cal[saec_pkg::CAL_W-1:0];
		awaited_readings.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_window();
			last_smoothed = '0;
			avg_len       = saec_pkg::WINDOW_LENGTH_RESET;
			alpha_q15     = saec_pkg::ALPHA_ONE;
			cal_gain      = saec_pkg::CAL_FACTOR_RESET;
			cal_bias      = saec_pkg::CAL_OFFSET_RESET;
			awaited_readings.delete();
			pending   = 0;
			compared  = 0;
			saturated = 0;
			failures  = 0;
		end else begin
			// Register request
			if (cfg_valid && cfg_ready)
				apply_register(saec_pkg::cfg_idx_t'(cfg_index), cfg_data);

			// Sample request: predict its reading
			if (sample_valid && !sample_stall)
				predict_reading(sample);

			// Result request: compare with the oldest prediction
			if (result_valid && !result_stall) begin
				if (awaited_readings.size() == 0) begin
					report_mismatch($sformatf("reading %0d / %0d with no sample pending",
						smoothed, calibrated));
				end else begin
					oldest = awaited_readings.pop_front();
					if (smoothed !== oldest.smoothed)
						report_mismatch($sformatf("smoothed got %0d, want %0d",
							smoothed, oldest.smoothed));
					if (calibrated !== oldest.calibrated)
						report_mismatch($sformatf("calibrated got %0d, want %0d",
							calibrated, $signed(oldest.calibrated)));
					compared++;
				end
			end
			pending = awaited_readings.size();
		end
	end

endmodule

>>> tb/sv/sensor_average_exp_calibrate_test.sv
`timescale 1ns / 1ps
// Top of the sensor_average_exp_calibrate testbench: clock, reset, register writes,
// sample and result traffic with random gaps, watchdog and verdict.
// Depends on saec_pkg, the block and sensor_average_exp_calibrate_check.
module sensor_average_exp_calibrate_test;

	localparam int SAMPLE_BITS   = saec_pkg::SAMPLE_BITS_DEFAULT;
	localparam int LEN_BITS      = saec_pkg::LEN_CFG_W;
	localparam int ALPHA_BITS    = saec_pkg::ALPHA_W;
	localparam int CAL_BITS      = saec_pkg::CAL_W;
	localparam int RANDOM_PHASES = 16;
	localparam int PHASE_SAMPLES = 100;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 4000;
	localparam int DRAIN_CYCLES  = 24;
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_TOP = '1;

	logic                               clk          = 1'b0;
	logic                               arst_n       = 1'b0;
	logic                               cfg_valid    = 1'b0;
	logic                               cfg_ready;
	logic [saec_pkg::CFG_IDX_W-1:0]     cfg_index    = '0;
	logic [CAL_BITS-1:0]                cfg_data     = '0;
	logic                               sample_valid = 1'b0;
	logic                               sample_stall;
	logic [SAMPLE_BITS-1:0]             sample       = '0;
	logic                               result_valid;
	logic                               result_stall = 1'b0;
	logic [SAMPLE_BITS-1:0]             smoothed;
	logic signed [CAL_BITS-1:0]         calibrated;

	int pending;
	int compared;
	int saturated;
	int failures;

	// Traffic shaping shared by the sender and the receiver
	bit tx_steady    = 1'b0;
	bit rx_steady    = 1'b0;
	int holds_asked  = 0;
	int holds_done   = 0;
	int samples_sent = 0;
	int settings     = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	sensor_average_exp_calibrate i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.smoothed     (smoothed),
		.calibrated   (calibrated)
	);

	sensor_average_exp_calibrate_check i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.smoothed     (smoothed),
		.calibrated   (calibrated),
		.pending      (pending),
		.compared     (compared),
		.saturated    (saturated),
		.failures     (failures)
	);

	// Mostly short gaps, now and then a long one
	function automatic int gap_length();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(20, 80);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int level);
		int v;
		case ($urandom_range(0, 7))
			0:       v = 0;
			1:       v = int'(SAMPLE_TOP);
			2, 3:    v = int'($urandom_range(0, SAMPLE_TOP));
			default: v = level + int'($urandom_range(0, 255)) - 128;
		endcase
		if (v < 0)
			v = 0;
		if (v > int'(SAMPLE_TOP))
			v = int'(SAMPLE_TOP);
		return v[SAMPLE_BITS-1:0];
	endfunction

	task automatic write_reg(input saec_pkg::cfg_idx_t idx, input logic [CAL_BITS-1:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Offer one sample after an optional gap; hold it until the request is taken
	task automatic push_sample(input logic [SAMPLE_BITS-1:0] s);
		int gap;
		gap = (tx_steady || $urandom_range(0, 1) == 0) ? 0 : gap_length();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do @(posedge clk); while (sample_stall);
		samples_sent++;
	endtask

	// Drop valid, wait for every reading, then let the sequencer settle
	task automatic close_phase();
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure_random();
		logic [CAL_BITS-1:0] d;
		int                  v;
		settings++;
		if ($urandom_range(0, 1) == 0) begin
			d = $urandom;
			case ($urandom_range(0, 9))
				0:       d[LEN_BITS-1:0] = LEN_BITS'(0);
				1:       d[LEN_BITS-1:0] = LEN_BITS'($urandom_range(17, 31));
				2:       d[LEN_BITS-1:0] = LEN_BITS'(16);
				3:       d[LEN_BITS-1:0] = LEN_BITS'(1);
				default: d[LEN_BITS-1:0] = LEN_BITS'($urandom_range(2, 15));
			endcase
			write_reg(saec_pkg::CFG_WINDOW_LENGTH, d);
		end
		if ($urandom_range(0, 3) != 0) begin
			d = $urandom;
			case ($urandom_range(0, 7))
				0:       d[ALPHA_BITS-1:0] = '0;
				1:       d[ALPHA_BITS-1:0] = saec_pkg::ALPHA_ONE;
				2:       d[ALPHA_BITS-1:0] = ALPHA_BITS'($urandom_range(32769, 65535));
				default: d[ALPHA_BITS-1:0] = ALPHA_BITS'($urandom_range(1, 32767));
			endcase
			write_reg(saec_pkg::CFG_SMOOTH_ALPHA, d);
		end
		if ($urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 7))
				0:       d = saec_pkg::CAL_MAX;
				1:       d = saec_pkg::CAL_MIN;
				2:       d = $urandom;
				3:       d = '0;
				default: begin
					v = int'($urandom_range(0, 1 << 19)) - (1 << 18);
					d = v;
				end
			endcase
			write_reg(saec_pkg::CFG_CAL_FACTOR, d);
		end
		if ($urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 5))
				0:       d = saec_pkg::CAL_MAX;
				1:       d = saec_pkg::CAL_MIN;
				2:       d = $urandom;
				default: begin
					v = int'($urandom_range(0, 1 << 27)) - (1 << 26);
					d = v;
				end
			endcase
			write_reg(saec_pkg::CFG_CAL_OFFSET, d);
		end
	endtask

	// Result side: random stalls, steady stretches, and the long hold-offs
	initial begin : result_side
		int run;
		@(posedge clk);
		forever begin
			if (holds_done < holds_asked) begin
				holds_done++;
				result_stall <= 1'b1;
				run = HOLD_CYCLES;
			end else if (rx_steady || $urandom_range(0, 2) != 0) begin
				result_stall <= 1'b0;
				run = $urandom_range(1, 16);
			end else begin
				result_stall <= 1'b1;
				run = gap_length();
			end
			repeat (run) @(posedge clk);
		end
	end

	// Abort when no request of any kind moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		do begin
			@(posedge clk);
			if ((cfg_valid && cfg_ready) || (sample_valid && !sample_stall) ||
			    (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end while (quiet < QUIET_LIMIT);
		$display("Timeout: no request moved for %0d cycles", QUIET_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		int level;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: identity calibration, no smoothing, window of one
		settings++;
		push_sample('0);
		push_sample(SAMPLE_TOP);
		push_sample(12'haaa);
		push_sample(12'h555);
		push_sample(12'h001);
		close_phase();

		// Zero window length, alpha above one, overflow upwards
		settings++;
		write_reg(saec_pkg::CFG_WINDOW_LENGTH, 32'hffff_ffe0);
		write_reg(saec_pkg::CFG_SMOOTH_ALPHA, 32'h0000_ffff);
		write_reg(saec_pkg::CFG_CAL_FACTOR, saec_pkg::CAL_MAX);
		write_reg(saec_pkg::CFG_CAL_OFFSET, saec_pkg::CAL_MAX);
		push_sample(SAMPLE_TOP);
		push_sample('0);
		push_sample(12'h001);
		close_phase();

		// Length above the maximum, alpha zero holds the reading, overflow downwards
		settings++;
		write_reg(saec_pkg::CFG_WINDOW_LENGTH, 32'h0000_001f);
		write_reg(saec_pkg::CFG_SMOOTH_ALPHA, 32'h0000_0000);
		write_reg(saec_pkg::CFG_CAL_FACTOR, saec_pkg::CAL_MIN);
		write_reg(saec_pkg::CFG_CAL_OFFSET, saec_pkg::CAL_MIN);
		push_sample(SAMPLE_TOP);
		push_sample(12'h800);
		push_sample(12'h007);
		close_phase();

		// Partly filled window of five with half smoothing, then wrap
		settings++;
		write_reg(saec_pkg::CFG_WINDOW_LENGTH, 32'd5);
		write_reg(saec_pkg::CFG_SMOOTH_ALPHA, 32'd16384);
		write_reg(saec_pkg::CFG_CAL_FACTOR, saec_pkg::CAL_FACTOR_RESET);
		write_reg(saec_pkg::CFG_CAL_OFFSET, 32'hffff_0000);
		repeat (7) push_sample(SAMPLE_TOP);
		close_phase();

		// Random phases, each under fresh settings
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			configure_random();
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			if (p == 3 || p == 11) begin
				tx_steady = 1'b1;
				rx_steady = 1'b0;
				holds_asked <= holds_asked + 1;
			end
			level = $urandom_range(0, SAMPLE_TOP);
			for (int i = 0; i < PHASE_SAMPLES; i++)
				push_sample(pick_sample(level));
			close_phase();
		end

		$display("Covered %0d samples under %0d register settings, %0d long hold-offs.",
			samples_sent, settings, holds_done);
		$display("Compared %0d readings, %0d of them saturated in calibration.",
			compared, saturated);
		if (failures == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
